// ----- rtl/core/iuc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iuc_pkg
// Shared constants for the interval union coverage block.
// ----------------------------------------------------------------------------
package iuc_pkg;
  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int COORD_BITS_DEF    = 30;
  localparam int START_W           = 30;
  localparam int STOP_W            = 31;
  localparam int CNT_W             = 31;
endpackage

// ----- rtl/core/iuc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iuc_in_if / iuc_out_if / iuc_cfg_if
// Valid/ready channels for interval words, results and configuration.
// ----------------------------------------------------------------------------
interface iuc_in_if;
  logic                          valid;
  logic                          ready;
  logic [iuc_pkg::START_W-1:0]   start_req;
  logic [iuc_pkg::STOP_W-1:0]    stop;
  modport source (output valid, start_req, stop, input ready);
  modport sink   (input valid, start_req, stop, output ready);
endinterface

interface iuc_out_if;
  logic                          valid;
  logic                          ready;
  logic [iuc_pkg::CNT_W-1:0]     covered;
  logic [iuc_pkg::CNT_W-1:0]     uncovered;
  logic                          overflow;
  modport source (output valid, covered, uncovered, overflow, input ready);
  modport sink   (input valid, covered, uncovered, overflow, output ready);
endinterface

interface iuc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [iuc_pkg::CNT_W-1:0]     data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/interval_union_coverage.sv -----
`timescale 1ns / 1ps
// Per word, the scan, the removal walk and the shift each step through the table
// entries by way of the RAM read port, so a word takes longer as the table fills.
// One word at a time; in.ready is low from acceptance until the result is taken.
// Synchronous active-high reset empties the table and clears the totals;
// RAM contents are not cleared, entries beyond the count are never read.
// ----------------------------------------------------------------------------
// interval_union_coverage
// Sorted disjoint interval table with running covered total.
// ----------------------------------------------------------------------------
module interval_union_coverage #(
  parameter int TABLE_ENTRIES = iuc_pkg::TABLE_ENTRIES_DEF
) (
  input logic clk,
  input logic rst,
  iuc_in_if.sink    in_ch,
  iuc_out_if.source out_ch,
  iuc_cfg_if.sink   cfg
);
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int NW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = iuc_pkg::START_W;
  localparam int EW = iuc_pkg::STOP_W;
  localparam int CW = iuc_pkg::CNT_W;
  localparam int COORD_BITS = iuc_pkg::COORD_BITS_DEF;
  localparam logic [NW-1:0] FULL = NW'(TABLE_ENTRIES);
  localparam logic [EW:0] LIMIT = (EW+1)'(1) << COORD_BITS;

  localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_SRD = 4'd2, S_SCMP = 4'd3,
                         S_LEFT = 4'd4, S_HRD = 4'd5, S_HCMP = 4'd6, S_DEC = 4'd7,
                         S_MRD = 4'd8, S_MWR = 4'd9, S_FIN = 4'd10, S_OUT = 4'd11;

  logic [3:0]    state;
  logic [NW-1:0] cnt, p, lo, hi, idx;
  logic [CW-1:0] covered_total, universe_size;
  logic [EW:0]   s, e, new_lo, sub;
  logic          ovf, is_left;

  // RAM ports
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [SW-1:0] ws, rs;
  logic [EW-1:0] wt, rt;

  iuc_ram #(.WIDTH(SW), .DEPTH(TABLE_ENTRIES)) u_starts (
    .clk(clk), .we(we), .waddr(waddr), .wdata(ws), .raddr(raddr), .rdata(rs));
  iuc_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_stops (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wt), .raddr(raddr), .rdata(rt));

  logic [EW:0] rsx, rtx;
  assign rsx = (EW+1)'(rs);
  assign rtx = (EW+1)'(rt);

  assign in_ch.ready  = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.covered  = covered_total;
  assign out_ch.uncovered = (universe_size > covered_total) ?
                            universe_size - covered_total : '0;
  assign out_ch.overflow = ovf;

  // shift source: moving entry idx-1 up to idx+shift, handled by copy lo+1+k <- hi+k
  logic [NW-1:0] mv_src, mv_dst;
  logic          up;          // shift direction: true when entries move right
  assign up = (hi == lo);

  always_comb begin
    raddr = idx[AW-1:0];
    if (state == S_MRD || state == S_MWR) raddr = mv_src[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      covered_total <= '0;
      universe_size <= '0;
      ovf <= 1'b0;
      is_left <= 1'b0;
      we <= 1'b0;
    end else begin
      we <= 1'b0;
      if (cfg.valid) universe_size <= cfg.data;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            s <= (EW+1)'(in_ch.start_req) & (LIMIT - 1'b1);
            e <= ((EW+1)'(in_ch.stop) > LIMIT) ? LIMIT : (EW+1)'(in_ch.stop);
            p <= '0; idx <= '0; sub <= '0; ovf <= 1'b0;
            state <= S_CHK;
          end
        end
        S_CHK: state <= (e <= s) ? S_OUT : S_SRD;
        S_SRD: begin
          if (idx < cnt) state <= S_SCMP;
          else begin
            idx <= (p == 0) ? p : p - 1'b1;
            state <= S_LEFT;
          end
        end
        S_SCMP: begin
          if (rsx <= s) begin
            p <= idx + 1'b1; idx <= idx + 1'b1; state <= S_SRD;
          end else begin
            idx <= (p == 0) ? p : p - 1'b1;
            state <= S_LEFT;
          end
        end
        S_LEFT: begin
          // idx holds p-1 here, so that entry is on the read port next cycle
          if (p == 0) begin
            lo <= '0; new_lo <= s; hi <= '0; idx <= '0; state <= S_HRD;
          end else begin
            idx <= p - 1'b1; is_left <= 1'b1; state <= S_HCMP;
          end
        end
        S_HRD: state <= (idx < cnt) ? S_HCMP : S_DEC;
        S_HCMP: begin
          if (is_left) begin
            is_left <= 1'b0;
            if (rtx >= e) state <= S_OUT;
            else begin
              if (rtx >= s) begin
                lo <= p - 1'b1; new_lo <= rsx; sub <= rtx - rsx;
              end else begin
                lo <= p; new_lo <= s;
              end
              hi <= p; idx <= p; state <= S_HRD;
            end
          end else if (rsx < e && rtx <= e) begin
            sub <= sub + (rtx - rsx); hi <= idx + 1'b1; idx <= idx + 1'b1;
            state <= S_HRD;
          end else if (hi == lo && cnt >= FULL) begin
            // no room for one more entry; table left as it is
            ovf <= 1'b1; state <= S_OUT;
          end else begin
            if (rsx < e) begin
              // trim right neighbour in place
              sub <= sub + (e - rsx);
              we <= 1'b1; waddr <= idx[AW-1:0];
              ws <= e[SW-1:0]; wt <= rt;
            end
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if (hi == lo && cnt >= FULL) begin
            ovf <= 1'b1; state <= S_OUT;
          end else begin
            covered_total <= CW'(covered_total - sub + (e - new_lo));
            if (hi == lo) begin
              mv_src <= cnt - 1'b1; mv_dst <= cnt;
            end else begin
              mv_src <= hi; mv_dst <= lo + 1'b1;
            end
            state <= S_MRD;
          end
        end
        S_MRD: begin
          if (up ? (mv_src + 1'b1 > lo && mv_dst > lo) : (mv_src < cnt))
            state <= S_MWR;
          else
            state <= S_FIN;
        end
        S_MWR: begin
          we <= 1'b1; waddr <= mv_dst[AW-1:0]; ws <= rs; wt <= rt;
          if (up) begin mv_src <= mv_src - 1'b1; mv_dst <= mv_dst - 1'b1; end
          else    begin mv_src <= mv_src + 1'b1; mv_dst <= mv_dst + 1'b1; end
          state <= S_MRD;
        end
        S_FIN: begin
          we <= 1'b1; waddr <= lo[AW-1:0];
          ws <= new_lo[SW-1:0]; wt <= e[EW-1:0];
          cnt <= cnt - (hi - lo) + 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (rst) cnt <= FULL)
    else $error("entry count above table size");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> $stable(covered_total))
    else $error("result changed while stalled");
`endif
endmodule

// ----- rtl/core/iuc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iuc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iuc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- tb/interval_union_coverage_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_union_coverage_tb
// Self-checking bench for the interval union block. A scoreboard keeps its own
// sorted interval table and predicts covered/uncovered/overflow for each word.
// Directed cases come first, then random intervals. Random gaps are applied
// on the input side and on the output side.
// ----------------------------------------------------------------------------
module interval_union_coverage_tb;

  localparam int       ENTRIES   = iuc_pkg::TABLE_ENTRIES_DEF;
  localparam longint   COORD_TOP = longint'(1) << iuc_pkg::COORD_BITS_DEF;
  localparam int       SW        = iuc_pkg::START_W;
  localparam int       EW        = iuc_pkg::STOP_W;
  localparam int       CW        = iuc_pkg::CNT_W;

  typedef struct {
    bit [CW-1:0] covered;
    bit [CW-1:0] uncovered;
    bit          overflow;
  } coverage_t;

  class coverage_scoreboard;
    longint    lo_tab[ENTRIES];
    longint    hi_tab[ENTRIES];
    int        n_entries;
    longint    covered_total;
    longint    universe;
    coverage_t expected_q[$];
    int        n_errors;

    function new();
      n_entries = 0;
      covered_total = 0;
      universe = 0;
      n_errors = 0;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      n_errors++;
    endtask

    function void queue_result(bit ovf);
      coverage_t r;
      longint cov;
      cov = covered_total & 64'h7FFF_FFFF;
      r.covered = cov[CW-1:0];
      r.uncovered = (universe > cov) ? CW'(universe - cov) : '0;
      r.overflow = ovf;
      expected_q.push_back(r);
    endfunction

    // apply one interval word to the table and queue the expected result
    function void note_interval(bit [SW-1:0] sreq, bit [EW-1:0] stp);
      longint s, e, new_lo, sub;
      int p, lo, hi, removed;
      bit trimmed;
      longint tail_lo[$], tail_hi[$];
      s = sreq;
      e = stp;
      if (e > COORD_TOP) e = COORD_TOP;
      if (e <= s) begin
        queue_result(0);
        return;
      end
      p = 0;
      while (p < n_entries && lo_tab[p] <= s) p++;
      lo = p;
      new_lo = s;
      if (p > 0) begin
        if (hi_tab[p-1] >= e) begin
          queue_result(0);
          return;
        end
        if (hi_tab[p-1] >= s) begin
          lo = p - 1;
          new_lo = lo_tab[p-1];
        end
      end
      hi = p;
      while (hi < n_entries && lo_tab[hi] < e && hi_tab[hi] <= e) hi++;
      trimmed = (hi < n_entries && lo_tab[hi] < e);
      removed = hi - lo;
      if (removed == 0 && n_entries >= ENTRIES) begin
        queue_result(1);
        return;
      end
      sub = 0;
      for (int i = lo; i < hi; i++) sub += hi_tab[i] - lo_tab[i];
      if (trimmed) begin
        sub += e - lo_tab[hi];
        lo_tab[hi] = e;
      end
      covered_total = (covered_total - sub + (e - new_lo)) & 64'h7FFF_FFFF;
      for (int i = hi; i < n_entries; i++) begin
        tail_lo.push_back(lo_tab[i]);
        tail_hi.push_back(hi_tab[i]);
      end
      lo_tab[lo] = new_lo;
      hi_tab[lo] = e;
      foreach (tail_lo[i]) begin
        lo_tab[lo+1+i] = tail_lo[i];
        hi_tab[lo+1+i] = tail_hi[i];
      end
      n_entries = n_entries - removed + 1;
      queue_result(0);
    endfunction

    task check_result(bit [CW-1:0] cov, bit [CW-1:0] unc, bit ovf);
      coverage_t x;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result cov=%0d unc=%0d ovf=%0b", cov, unc, ovf));
        return;
      end
      x = expected_q.pop_front();
      if (cov !== x.covered)
        report($sformatf("covered %0d, want %0d", cov, x.covered));
      if (unc !== x.uncovered)
        report($sformatf("uncovered %0d, want %0d", unc, x.uncovered));
      if (ovf !== x.overflow)
        report($sformatf("overflow %0b, want %0b", ovf, x.overflow));
    endtask
  endclass

  logic clk;
  logic rst;

  iuc_in_if  in_ch ();
  iuc_out_if out_ch ();
  iuc_cfg_if cfg ();

  interval_union_coverage uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  coverage_scoreboard sb;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end

  // sender gap: a random idle gap before each word, except in a burst stretch
  task automatic send_interval(bit [SW-1:0] s, bit [EW-1:0] e);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.start_req <= s;
    in_ch.stop      <= e;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    sb.note_interval(s, e);
  endtask

  task automatic write_universe(bit [CW-1:0] val);
    in_ch.valid <= 1'b0;
    cfg.valid   <= 1'b1;
    cfg.data    <= val;
    do @(negedge clk); while (!cfg.ready);
    @(posedge clk);
    cfg.valid <= 1'b0;
    sb.universe = val;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_interval();
    bit [SW-1:0] s;
    bit [EW-1:0] e;
    int mode;
    mode = $urandom_range(0, 11);
    if (mode == 0) begin
      s = SW'($urandom());
      e = EW'($urandom_range(0, s));
    end else if (mode == 1) begin
      s = SW'($urandom());
      e = EW'($urandom());
    end else if (mode == 2) begin
      s = SW'($urandom_range(0, 8191));
      e = EW'(s + $urandom_range(1, 4096));
    end else begin
      s = SW'($urandom_range(0, 8191));
      e = EW'(s + $urandom_range(1, 96));
    end
    send_interval(s, e);
  endtask

  // result side: random stalls, with stretches of none
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.covered, out_ch.uncovered, out_ch.overflow);
      @(posedge clk);
    end
  end

  initial begin
    sb = new();
    no_gaps = 1'b0;
    rst = 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.start_req <= '0;
    in_ch.stop <= '0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    write_universe(1000);
    send_interval(5, 5);                 // empty
    send_interval(10, 3);                // stop below start
    send_interval(0, 1);
    send_interval(100, 200);
    send_interval(120, 150);             // already covered
    send_interval(200, 300);             // touching left merges
    send_interval(50, 60);
    send_interval(40, 120);              // swallows an entry, trims right
    send_interval(400, 500);
    send_interval(350, 500);             // right neighbour ends at stop
    send_interval(600, 700);
    send_interval(550, 600);             // right neighbour starts at stop
    send_interval(0, 1000);
    send_interval(1100, 1200);           // covered above universe
    send_interval(30'h3FFF_FFFF, 31'h7FFF_FFFF);  // stop saturates
    send_interval(30'h3FFF_FFFE, 31'h4000_0000);
    send_interval(30'h2AAA_AAAA, 31'h5555_5555);
    drain();

    write_universe(0);
    for (int i = 0; i < 560; i++) begin
      if (i % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (i == 200 || i == 400) begin
        drain();
        write_universe(i == 200 ? CW'($urandom_range(0, 20000)) :
                                  CW'($urandom_range(0, 1 << 30)));
      end
      random_interval();
    end
    drain();

    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
